/* rtl/clns_pkg.sv */
package clns_pkg;

   // Field widths
   localparam int unsigned TickW  = 20;
   localparam int unsigned ByteW  = 8;
   localparam int unsigned NibW   = 4;
   localparam int unsigned KindW  = 2;
   localparam int unsigned CsrIdxW = 2;

   // Register reset values
   localparam logic [TickW-1:0] SetupReset = 20'd100000;
   localparam logic [TickW-1:0] PulseReset = 20'd50000;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CSR_SETUP = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_PULSE = 2'd1;

   // Request kinds
   localparam logic [KindW-1:0] KIND_CHAR = 2'd0;
   localparam logic [KindW-1:0] KIND_CMD  = 2'd1;
   localparam logic [KindW-1:0] KIND_INIT = 2'd2;

   localparam logic [ByteW-1:0] NewlineCode = 8'h0A;
   localparam logic [ByteW-1:0] LineTwoCmd  = 8'hC0;

   // Microprogram: seven steps per byte
   localparam int unsigned StepCount = 7;
   localparam int unsigned StepW     = $clog2(StepCount);

   // Initialise-and-clear command list
   localparam int unsigned InitLen = 6;
   localparam int unsigned InitW   = $clog2(InitLen);
   localparam logic [InitW-1:0] InitLast = InitW'(InitLen - 1);

   typedef struct packed {
      logic setup_seg;  // hold previous pins, setup hold time
      logic enable;     // E level
      logic low_nib;    // 0: high nibble, 1: low nibble
      logic end_byte;   // final step of a byte: jump back or finish
   } uword_type;

   function automatic uword_type micro_word(input logic [StepW-1:0] step);
      uword_type w;
      w = '{setup_seg: 1'b0, enable: 1'b0, low_nib: 1'b0, end_byte: 1'b0};
      case (step)
         3'd0: w.setup_seg = 1'b1;
         3'd1: w.enable    = 1'b0;
         3'd2: w.enable    = 1'b1;
         3'd3: w.enable    = 1'b0;
         3'd4: w.low_nib   = 1'b1;
         3'd5: begin
            w.low_nib = 1'b1;
            w.enable  = 1'b1;
         end
         3'd6: begin
            w.low_nib  = 1'b1;
            w.end_byte = 1'b1;
         end
         default: w.end_byte = 1'b1;
      endcase
      return w;
   endfunction

   function automatic logic [ByteW-1:0] init_byte(input logic [InitW-1:0] idx);
      logic [ByteW-1:0] b;
      case (idx)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h28;
         3'd3:    b = 8'h0C;
         3'd4:    b = 8'h06;
         3'd5:    b = 8'h01;
         default: b = 8'h01;
      endcase
      return b;
   endfunction

   // A hold register written as zero still holds for one tick
   function automatic logic [TickW-1:0] hold_of(input logic [TickW-1:0] v);
      return (v == '0) ? TickW'(1) : v;
   endfunction

endpackage

/* rtl/char_lcd_nibble_sequencer.sv */
// An accepted request sets busy; busy then loads pin segments into the output register.
// Throughput: one segment per cycle while rsp_stall is low, 7 per byte from the 7-step
//   microprogram; req_stall holds until the last segment is loaded, so the next request is
//   taken only after that; an unused-kind request is swallowed without setting busy.
// Reset (synchronous, active high): setup_ticks 100000, pulse_ticks 50000, previous pin
//   levels zero, sequencer idle, output register empty.
module char_lcd_nibble_sequencer
   import clns_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KindW-1:0]   req_kind,
   input  logic [ByteW-1:0]   req_value,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_reg_select,
   output logic               rsp_enable_pin,
   output logic [NibW-1:0]    rsp_nibble,
   output logic [TickW-1:0]   rsp_hold_ticks,
   output logic               rsp_last,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [TickW-1:0]   csr_data
);

   // Configuration registers
   logic [TickW-1:0] setup_ff, setup_in;
   logic [TickW-1:0] pulse_ff, pulse_in;

   // Pin levels left by the last byte sent
   logic            prev_rs_ff, prev_rs_in;
   logic [NibW-1:0] prev_nib_ff, prev_nib_in;

   // Sequencer control
   logic             busy_ff, busy_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             init_ff, init_in;
   logic [InitW-1:0] idx_ff, idx_in;

   // Byte being sent (plain requests) and its RS level
   logic [ByteW-1:0] byte_ff, byte_in;
   logic             rs_ff, rs_in;

   // Output register
   logic             out_valid_ff, out_valid_in;
   logic             out_rs_ff, out_rs_in;
   logic             out_e_ff, out_e_in;
   logic [NibW-1:0]  out_nib_ff, out_nib_in;
   logic [TickW-1:0] out_hold_ff, out_hold_in;
   logic             out_last_ff, out_last_in;

   uword_type        uw;
   logic [ByteW-1:0] cur_byte;
   logic [NibW-1:0]  cur_nib;
   logic             req_accept;
   logic             advance;
   logic             final_byte;

   assign csr_ready = 1'b1;
   assign req_stall = busy_ff;
   assign req_accept = req_valid && !req_stall;

   // Segment goes out when the output register is empty or being drained
   assign advance = busy_ff && (!out_valid_ff || !rsp_stall);

   // Control word for the current step
   assign uw = micro_word(step_ff);

   // The init list is read straight from the command table
   assign cur_byte   = init_ff ? init_byte(idx_ff) : byte_ff;
   assign cur_nib    = uw.low_nib ? cur_byte[NibW-1:0] : cur_byte[ByteW-1:NibW];
   assign final_byte = !init_ff || (idx_ff == InitLast);

   always_comb begin
      setup_in     = setup_ff;
      pulse_in     = pulse_ff;
      prev_rs_in   = prev_rs_ff;
      prev_nib_in  = prev_nib_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      init_in      = init_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      rs_in        = rs_ff;
      out_valid_in = out_valid_ff;
      out_rs_in    = out_rs_ff;
      out_e_in     = out_e_ff;
      out_nib_in   = out_nib_ff;
      out_hold_in  = out_hold_ff;
      out_last_in  = out_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SETUP: setup_in = csr_data;
            CSR_PULSE: pulse_in = csr_data;
            default:   ;
         endcase
      end

      // Output register drains when taken
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // New request: load the byte (or select the init list) and restart the microprogram.
      // Unused kind is swallowed.
      if (req_accept) begin
         step_in = '0;
         idx_in  = '0;
         case (req_kind)
            KIND_CHAR: begin
               busy_in = 1'b1;
               init_in = 1'b0;
               if (req_value == NewlineCode) begin
                  byte_in = LineTwoCmd;
                  rs_in   = 1'b0;
               end else begin
                  byte_in = req_value;
                  rs_in   = 1'b1;
               end
            end
            KIND_CMD: begin
               busy_in = 1'b1;
               init_in = 1'b0;
               byte_in = req_value;
               rs_in   = 1'b0;
            end
            KIND_INIT: begin
               busy_in = 1'b1;
               init_in = 1'b1;
               rs_in   = 1'b0;
            end
            default: ;
         endcase
      end

      if (advance) begin
         out_valid_in = 1'b1;
         out_e_in     = uw.enable;
         out_last_in  = uw.end_byte && final_byte;
         if (uw.setup_seg) begin
            out_rs_in   = prev_rs_ff;
            out_nib_in  = prev_nib_ff;
            out_hold_in = hold_of(setup_ff);
         end else begin
            out_rs_in   = rs_ff;
            out_nib_in  = cur_nib;
            out_hold_in = hold_of(pulse_ff);
         end

         if (uw.end_byte) begin
            // Byte done: remember pins, then loop for the next init byte or finish
            prev_rs_in  = rs_ff;
            prev_nib_in = cur_byte[NibW-1:0];
            step_in     = '0;
            if (final_byte) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff + InitW'(1);
            end
         end else begin
            step_in = step_ff + StepW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff     <= SetupReset;
         pulse_ff     <= PulseReset;
         prev_rs_ff   <= 1'b0;
         prev_nib_ff  <= '0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         init_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         setup_ff     <= setup_in;
         pulse_ff     <= pulse_in;
         prev_rs_ff   <= prev_rs_in;
         prev_nib_ff  <= prev_nib_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         init_ff      <= init_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rs_ff       <= rs_in;
      out_rs_ff   <= out_rs_in;
      out_e_ff    <= out_e_in;
      out_nib_ff  <= out_nib_in;
      out_hold_ff <= out_hold_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_enable_pin = out_e_ff;
   assign rsp_nibble     = out_nib_ff;
   assign rsp_hold_ticks = out_hold_ff;
   assign rsp_last       = out_last_ff;

endmodule

/* verif/lcd_segment_checker.sv */
`timescale 1ns / 1ps

module lcd_segment_checker
   import clns_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [KindW-1:0]   req_kind,
   input  logic [ByteW-1:0]   req_value,

   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_reg_select,
   input  logic               rsp_enable_pin,
   input  logic [NibW-1:0]    rsp_nibble,
   input  logic [TickW-1:0]   rsp_hold_ticks,
   input  logic               rsp_last,

   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [TickW-1:0]   csr_data,

   output int unsigned        mismatch_count,
   output int unsigned        segs_owed
);

   typedef struct packed {
      logic             rs;
      logic             e;
      logic [NibW-1:0]  nib;
      logic [TickW-1:0] hold;
      logic             last;
   } pin_seg_type;

   // power-up command list, first command in the top byte
   localparam logic [6*ByteW-1:0] PowerUpCmds = {8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};

   pin_seg_type      seg_q[$];
   logic [TickW-1:0] setup_hold;
   logic [TickW-1:0] pulse_hold;
   logic             prev_rs;
   logic [NibW-1:0]  prev_nib;

   initial begin
      mismatch_count = 0;
      segs_owed      = 0;
   end

   function automatic logic [TickW-1:0] ticks_or_one(input logic [TickW-1:0] t);
      return (t == '0) ? TickW'(1) : t;
   endfunction

   function automatic pin_seg_type mk_seg(input logic rs, input logic e,
                                          input logic [NibW-1:0] nib,
                                          input logic [TickW-1:0] hold);
      pin_seg_type s;
      s.rs   = rs;
      s.e    = e;
      s.nib  = nib;
      s.hold = hold;
      s.last = 1'b0;
      return s;
   endfunction

   // setup wait on old pins, then high nibble and low nibble, three segments each
   task automatic queue_byte_segs(input logic [ByteW-1:0] b, input logic rs);
      logic [NibW-1:0]  nibs [2];
      logic [TickW-1:0] pulse;
      pulse   = ticks_or_one(pulse_hold);
      nibs[0] = b[7:4];
      nibs[1] = b[3:0];
      seg_q.push_back(mk_seg(prev_rs, 1'b0, prev_nib, ticks_or_one(setup_hold)));
      for (int i = 0; i < 2; i++) begin
         seg_q.push_back(mk_seg(rs, 1'b0, nibs[i], pulse));
         seg_q.push_back(mk_seg(rs, 1'b1, nibs[i], pulse));
         seg_q.push_back(mk_seg(rs, 1'b0, nibs[i], pulse));
      end
      prev_rs  = rs;
      prev_nib = nibs[1];
   endtask

   task automatic predict_lcd_request(input logic [KindW-1:0] kind,
                                      input logic [ByteW-1:0] value);
      pin_seg_type tail;
      case (kind)
         KIND_CHAR: begin
            if (value == NewlineCode) queue_byte_segs(LineTwoCmd, 1'b0);
            else queue_byte_segs(value, 1'b1);
         end
         KIND_CMD: queue_byte_segs(value, 1'b0);
         KIND_INIT: begin
            for (int i = 0; i < InitLen; i++)
               queue_byte_segs(PowerUpCmds[(InitLen-1-i)*ByteW +: ByteW], 1'b0);
         end
         default: return;
      endcase
      tail      = seg_q.pop_back();
      tail.last = 1'b1;
      seg_q.push_back(tail);
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      pin_seg_type want;
      if (reset) begin
         setup_hold = SetupReset;
         pulse_hold = PulseReset;
         prev_rs    = 1'b0;
         prev_nib   = '0;
         seg_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SETUP: setup_hold = csr_data;
               CSR_PULSE: pulse_hold = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_lcd_request(req_kind, req_value);
         if (rsp_valid && !rsp_stall) begin
            if (seg_q.size() == 0) begin
               $error("rsp: segment with no request outstanding");
               mismatch_count++;
            end else begin
               want = seg_q.pop_front();
               check_field("reg_select", 32'(want.rs),   32'(rsp_reg_select));
               check_field("enable_pin", 32'(want.e),    32'(rsp_enable_pin));
               check_field("nibble",     32'(want.nib),  32'(rsp_nibble));
               check_field("hold_ticks", 32'(want.hold), 32'(rsp_hold_ticks));
               check_field("last",       32'(want.last), 32'(rsp_last));
            end
         end
      end
      segs_owed = seg_q.size();
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import clns_pkg::*;

   // kind 3 has no meaning; the block must swallow it
   localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

   localparam int ItemsPerPhase = 30;  // counted requests per random phase
   localparam int Phases        = 5;
   localparam int SettleCycles  = 6;   // covers an unused-kind request still in flight
   localparam int HoldOffCycles = 400; // long receiver back-pressure

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [KindW-1:0]   req_kind  = '0;
   logic [ByteW-1:0]   req_value = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_reg_select;
   logic               rsp_enable_pin;
   logic [NibW-1:0]    rsp_nibble;
   logic [TickW-1:0]   rsp_hold_ticks;
   logic               rsp_last;

   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [TickW-1:0]   csr_data  = '0;

   int unsigned        mismatch_count;
   int unsigned        segs_owed;

   // idle control shared by both sides
   logic               no_idle      = 1'b0;
   int unsigned        hold_asked   = 0;
   int unsigned        hold_granted = 0;
   int unsigned        hold_left    = 0;

   char_lcd_nibble_sequencer i_dut (.*);

   lcd_segment_checker i_checker (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Give up well past the slowest legal run
   initial begin
      #2_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Receiver side: random stalls, none in the quiet phase, and a long
   // hold-off whenever the stimulus asks for one (counted here).
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_granted) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HoldOffCycles;
         hold_granted <= hold_asked;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 29);
      end
   end

   // Offer one request, with random idle cycles in front of it unless the
   // quiet phase is on; returns at the edge where it was taken.
   task automatic send_request(input logic [KindW-1:0] kind, input logic [ByteW-1:0] value);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering, wait for every owed segment, then let the block settle.
   // Polling on the falling edge keeps clear of the checker's updates.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (segs_owed != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [TickW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // A stray write to an unused index first, which must change nothing
   task automatic program_holds(input logic [TickW-1:0] setup, input logic [TickW-1:0] pulse);
      csr_write(CsrIdxW'(CSR_PULSE + 1 + $urandom_range(1)), TickW'($urandom));
      csr_write(CSR_SETUP, setup);
      csr_write(CSR_PULSE, pulse);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned      sent;
      int unsigned      roll;
      logic [KindW-1:0] kind;
      logic [ByteW-1:0] value;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset hold values ---
      send_request(KIND_CHAR, 8'h48);
      send_request(KIND_CHAR, 8'h00);        // NUL is just a character
      send_request(KIND_CHAR, 8'hFF);
      send_request(KIND_CHAR, NewlineCode);  // becomes the second-line command
      send_request(KIND_CMD, 8'h00);
      send_request(KIND_CMD, 8'hFF);
      send_request(KIND_CMD, NewlineCode);   // raw command, no newline mapping
      send_request(KIND_CMD, LineTwoCmd);
      send_request(KIND_INIT, 8'hA5);        // value ignored on power-up sequence
      send_request(KIND_UNUSED, 8'h5A);
      send_request(KIND_CHAR, 8'h55);
      send_request(KIND_CHAR, 8'hAA);
      wait_drained();

      // zero hold values must come out as one tick
      program_holds('0, '0);
      send_request(KIND_INIT, 8'h00);
      send_request(KIND_UNUSED, 8'hFF);
      send_request(KIND_CHAR, 8'h7E);
      send_request(KIND_CMD, 8'h81);
      wait_drained();

      // all-ones, the largest 20-bit hold values
      program_holds('1, '1);
      send_request(KIND_CHAR, NewlineCode);
      send_request(KIND_CHAR, 8'hF0);
      send_request(KIND_CMD, 8'h0F);
      send_request(KIND_INIT, 8'hFF);
      wait_drained();

      // --- random phases, each under its own hold settings ---
      for (int p = 0; p < Phases; p++) begin
         case (p)
            1:       program_holds(TickW'(1), TickW'(1_000_000));
            3:       program_holds('0, TickW'(1));
            4:       program_holds(SetupReset, PulseReset);
            default: program_holds(TickW'($urandom_range(20'hFFFFF)),
                                   TickW'($urandom_range(20'hFFFFF)));
         endcase
         // phase 2 runs with no idling on either side
         no_idle <= (p == 2);
         // phase 1 opens with a long receiver hold-off so the block backs up
         if (p == 1) hold_asked <= hold_asked + 1;

         sent = 0;
         while (sent < ItemsPerPhase) begin
            roll  = $urandom_range(99);
            value = ByteW'($urandom);
            if (roll < 45) begin
               kind = KIND_CHAR;
            end else if (roll < 52) begin
               kind  = KIND_CHAR;
               value = NewlineCode;
            end else if (roll < 84) begin
               kind = KIND_CMD;
            end else if (roll < 93) begin
               kind = KIND_INIT;
            end else begin
               kind = KIND_UNUSED;
            end
            send_request(kind, value);
            if (kind != KIND_UNUSED) sent++;
            // sender pause half way through phase 3 until all segments are in
            if (p == 3 && sent == ItemsPerPhase / 2) wait_drained();
         end
         wait_drained();
      end

      no_idle <= 1'b0;
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && segs_owed == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
